### rtl/clds_pkg.sv
// ----------------------------------------------------------------------------
// clds_pkg
// Shared types and codes for the ring deque with key search.
// ----------------------------------------------------------------------------
package clds_pkg;

  // Payload widths fixed by the interface
  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCOUNT_W = 5;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } state_t;

endpackage

### rtl/clds_ram.sv
// ----------------------------------------------------------------------------
// clds_ram
// Single-port element store, synchronous write, registered read.
// ----------------------------------------------------------------------------
module clds_ram #(
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [clds_pkg::VALUE_W-1:0] wdata,
  output logic [clds_pkg::VALUE_W-1:0] rdata
);

  logic [clds_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write on request, read the addressed entry every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/circular_list_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// circular_list_deque_with_search_unit
// Bounded ring deque of signed 32-bit values with head/tail insert, head
// removal and a key search that walks the held entries.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ---------------------
//   request  in_mode, in_value                       start && !busy
//   result   out_status, out_removed_value,          out_valid, one cycle
//            out_found, out_entry_count
//
// For inserts and refused requests the result appears the cycle after the
// item is taken, and busy stays low so the next item may follow.
// A removal does one store read of the head, then gives the result.
// A search does one store read per held entry,
// stopping at the first match.
// Reset (rst_n low, synchronous) empties the list; store contents stay as
// they were. The receiver cannot stall, so each result shows for one cycle.
// ----------------------------------------------------------------------------
module circular_list_deque_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [clds_pkg::MODE_W-1:0]   in_mode,
  input  logic signed [clds_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_valid,
  output logic        [clds_pkg::STATUS_W-1:0] out_status,
  output logic signed [clds_pkg::VALUE_W-1:0]  out_removed_value,
  output logic                                 out_found,
  output logic        [clds_pkg::OCOUNT_W-1:0] out_entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  clds_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             k_r, k_nxt;
  logic [clds_pkg::VALUE_W-1:0] key_r, key_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [clds_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [clds_pkg::VALUE_W-1:0]  out_removed_r, out_removed_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [clds_pkg::OCOUNT_W-1:0] out_count_r, out_count_nxt;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_addr;
  logic [clds_pkg::VALUE_W-1:0]  mem_wdata;
  logic [clds_pkg::VALUE_W-1:0]  mem_rdata;

  logic                          accept;
  logic                          is_full;
  logic                          is_empty;
  logic [CNT_W-1:0]              slot_off;
  logic [SUM_W-1:0]              slot_sum;
  logic [IDX_W-1:0]              slot_idx;
  logic [IDX_W-1:0]              head_dec;
  logic [IDX_W-1:0]              head_inc;
  logic                          hit;
  logic                          walk_done;
  logic [31:0]                   count_ext;

  // Element store
  clds_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Request decode and ring arithmetic
  assign busy      = (state_r != clds_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign head_dec  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign hit       = (mem_rdata == key_r);
  assign walk_done = (k_r == count_r);

  // Offset from head to ring slot, wrapped by one compare and subtract
  always_comb begin
    slot_off = (state_r == clds_pkg::S_SEARCH) ? k_r : count_r;
    slot_sum = SUM_W'(head_r) + SUM_W'(slot_off);
    if (slot_sum >= SUM_W'(DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(DEPTH);
    end
    slot_idx = slot_sum[IDX_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clds_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == clds_pkg::MODE_POP_HEAD && !is_empty) begin
            state_nxt = clds_pkg::S_POP;
          end else if (in_mode == clds_pkg::MODE_SEARCH && !is_empty) begin
            state_nxt = clds_pkg::S_SEARCH;
          end
        end
      end
      clds_pkg::S_POP: begin
        state_nxt = clds_pkg::S_IDLE;
      end
      clds_pkg::S_SEARCH: begin
        if (hit || walk_done) begin
          state_nxt = clds_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clds_pkg::S_IDLE;
      end
    endcase
  end

  // Store access, pointer update and result
  always_comb begin
    mem_we          = 1'b0;
    mem_addr        = head_r;
    mem_wdata       = in_value;
    head_nxt        = head_r;
    count_nxt       = count_r;
    k_nxt           = k_r;
    key_nxt         = key_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = clds_pkg::ST_OK;
    out_removed_nxt = '0;
    out_found_nxt   = 1'b0;
    unique case (state_r)
      clds_pkg::S_IDLE: begin
        if (accept) begin
          key_nxt = in_value;
          k_nxt   = CNT_W'(1);
          unique case (in_mode)
            clds_pkg::MODE_PUSH_HEAD: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = clds_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            clds_pkg::MODE_PUSH_TAIL: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = clds_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = slot_idx;
                count_nxt = count_r + 1'b1;
              end
            end
            clds_pkg::MODE_POP_HEAD: begin
              // read the head now, finish next cycle
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = clds_pkg::ST_EMPTY;
              end
            end
            clds_pkg::MODE_SEARCH: begin
              // read offset zero now, walk on from offset one
              if (is_empty) begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      clds_pkg::S_POP: begin
        out_valid_nxt   = 1'b1;
        out_removed_nxt = mem_rdata;
        count_nxt       = count_r - 1'b1;
        head_nxt        = (count_r == CNT_W'(1)) ? '0 : head_inc;
      end
      clds_pkg::S_SEARCH: begin
        if (hit || walk_done) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit;
        end else begin
          mem_addr = slot_idx;
          k_nxt    = k_r + 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    count_ext     = 32'(count_nxt);
    out_count_nxt = count_ext[clds_pkg::OCOUNT_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clds_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_found         = out_found_r;
  assign out_entry_count   = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("held count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < 32'(DEPTH))
    else $error("head index outside ring");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0)
    else $error("empty list with head away from zero");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_status_r == clds_pkg::ST_OK &&
      out_removed_r == '0)
    else $error("search hit with bad status or removed value");

  a_pop_enter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == clds_pkg::MODE_POP_HEAD && !is_empty |=>
      state_r == clds_pkg::S_POP)
    else $error("removal did not enter pop state");
`endif

endmodule

### verif/circular_list_deque_with_search_unit_tb.sv
// ----------------------------------------------------------------------------
// circular_list_deque_with_search_unit_tb
// Self-checking bench for the ring deque with key search. Requests go in
// through the start/busy handshake. A scoreboard keeps its own copy of the
// ring and predicts one result per accepted item. Each strobed result is then
// checked field by field. Directed items cover the empty and full edges and
// the extreme values. Random fill/drain runs follow, with sender gaps that
// change from phase to phase.
// ----------------------------------------------------------------------------
module circular_list_deque_with_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CYCLE_CAP = 200000;
  localparam int RAND_ITEMS_PER_PHASE = 185;

  typedef logic        [clds_pkg::MODE_W-1:0]   mode_t;
  typedef logic signed [clds_pkg::VALUE_W-1:0]  value_t;
  typedef logic        [clds_pkg::STATUS_W-1:0] status_t;
  typedef logic        [clds_pkg::OCOUNT_W-1:0] count_t;

  typedef struct {
    status_t status;
    value_t  removed_value;
    logic    found;
    count_t  entry_count;
  } deque_result_t;

  // Ring shadow plus the queue of results still owed by the block
  class deque_scoreboard;
    value_t           slots [DEPTH];
    logic [IDX_W-1:0] ring_head;
    int               fill;
    deque_result_t    owed_q[$];
    int errors, items, full_hits, empty_hits, search_hits;

    function new();
      ring_head = '0;
      fill = 0;
      errors = 0;
      items = 0;
      full_hits = 0;
      empty_hits = 0;
      search_hits = 0;
    endfunction

    function value_t held_value(int k);
      logic [IDX_W-1:0] idx;
      idx = ring_head + IDX_W'(k);
      return slots[idx];
    endfunction

    // Predict the result of one accepted item and advance the shadow
    function void note_item(mode_t mode, value_t value);
      deque_result_t    r;
      logic [IDX_W-1:0] idx;
      r.status = clds_pkg::ST_OK;
      r.removed_value = '0;
      r.found = 1'b0;
      items++;
      case (mode) inside
        clds_pkg::MODE_PUSH_HEAD, clds_pkg::MODE_PUSH_TAIL: begin
          if (fill == DEPTH) begin
            r.status = clds_pkg::ST_FULL;
            full_hits++;
          end else if (mode == clds_pkg::MODE_PUSH_HEAD) begin
            ring_head = ring_head - 1'b1;
            slots[ring_head] = value;
            fill++;
          end else begin
            idx = ring_head + IDX_W'(fill);
            slots[idx] = value;
            fill++;
          end
        end
        clds_pkg::MODE_POP_HEAD: begin
          if (fill == 0) begin
            r.status = clds_pkg::ST_EMPTY;
            empty_hits++;
          end else begin
            r.removed_value = slots[ring_head];
            ring_head = ring_head + 1'b1;
            fill--;
            if (fill == 0) ring_head = '0;
          end
        end
        default: begin
          for (int k = 0; k < fill; k++)
            if (held_value(k) == value) r.found = 1'b1;
          if (r.found) search_hits++;
        end
      endcase
      r.entry_count = count_t'(fill);
      owed_q.push_back(r);
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(deque_result_t got);
      deque_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, got %0d", want.removed_value,
               got.removed_value);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count,
               got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  mode_t   in_mode = clds_pkg::MODE_SEARCH;
  value_t  in_value = '0;
  logic    out_valid;
  status_t out_status;
  value_t  out_removed_value;
  logic    out_found;
  count_t  out_entry_count;

  deque_scoreboard sb = new();
  int              gap_pct = 0;
  int              cycles = 0;

  circular_list_deque_with_search_unit #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_found         (out_found),
    .out_entry_count   (out_entry_count)
  );

  always #4 clk = ~clk;

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Take each strobed result; the receiver never holds off
  always @(posedge clk) begin
    deque_result_t got;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.removed_value = out_removed_value;
      got.found = out_found;
      got.entry_count = out_entry_count;
      sb.check_result(got);
    end
  end

  // Offer one item, hold it until taken, then maybe leave a gap
  task automatic send_item(mode_t mode, value_t value);
    start <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    do @(posedge clk); while (busy);
    sb.note_item(mode, value);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return value_t'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic value_t pick_key();
    if (sb.fill > 0 && $urandom_range(0, 1))
      return sb.held_value($urandom_range(0, sb.fill - 1));
    return pick_value();
  endfunction

  initial begin
    int    phase_gap [4];
    int    insert_bias;
    mode_t mode;

    phase_gap = '{0, 45, 0, 12};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty edge, extremes, then fill to full and refuse
    send_item(clds_pkg::MODE_POP_HEAD, 32'sd0);
    send_item(clds_pkg::MODE_SEARCH, 32'sd0);
    send_item(clds_pkg::MODE_PUSH_HEAD, 32'sh8000_0000);
    send_item(clds_pkg::MODE_PUSH_TAIL, 32'sh7fff_ffff);
    send_item(clds_pkg::MODE_SEARCH, 32'sh8000_0000);
    send_item(clds_pkg::MODE_SEARCH, 32'sh7fff_ffff);
    send_item(clds_pkg::MODE_SEARCH, 32'sd0);
    send_item(clds_pkg::MODE_POP_HEAD, 32'sd0);
    repeat (DEPTH - 1)
      send_item($urandom_range(0, 1) ? clds_pkg::MODE_PUSH_HEAD : clds_pkg::MODE_PUSH_TAIL,
                pick_value());
    send_item(clds_pkg::MODE_PUSH_HEAD, 32'sh1234_5678);
    send_item(clds_pkg::MODE_PUSH_TAIL, -32'sd1);

    // Random fill/drain runs; the bias flips at the full and empty edges
    insert_bias = 20;
    foreach (phase_gap[p]) begin
      gap_pct = phase_gap[p];
      repeat (RAND_ITEMS_PER_PHASE) begin
        if (sb.fill == DEPTH) insert_bias = 20;
        else if (sb.fill == 0) insert_bias = 80;
        else if ($urandom_range(0, 39) == 0) insert_bias = $urandom_range(30, 70);
        if ($urandom_range(0, 99) < 25) begin
          send_item(clds_pkg::MODE_SEARCH, pick_key());
        end else begin
          if ($urandom_range(0, 99) < insert_bias)
            mode = $urandom_range(0, 1) ? clds_pkg::MODE_PUSH_HEAD
                                        : clds_pkg::MODE_PUSH_TAIL;
          else
            mode = clds_pkg::MODE_POP_HEAD;
          send_item(mode, pick_value());
        end
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for a full search walk
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    sb.errors += sb.owed_q.size();

    $display("Run covered %0d items over %0d gap settings.", sb.items, 4);
    $display("Refused as full: %0d, removals on empty: %0d, search hits: %0d.",
             sb.full_hits, sb.empty_hits, sb.search_hits);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
